FILE: design/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types, codes and sizes of the HTTP body dechunker.
// ----------------------------------------------------------------------------
package hbd_pkg;

	// default width of the byte counter / chunk size register
	localparam int HBD_LEN_WIDTH = 32;

	// field widths fixed by the interface
	localparam int BODY_LEN_W = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int ERR_W      = 2;

	// depth of the queue between front and back
	localparam int HBD_Q_DEPTH = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNKED_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_PRESENT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH    = 2'd2;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FRAMING   = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EARLY_END = 2'd2;

	// input commands
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// configuration register file
	typedef struct packed {
		logic                  chunked_mode;
		logic                  length_present;
		logic [BODY_LEN_W-1:0] body_length;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_cr;
		logic       is_lf;
	} item_t;

	// one result transaction
	typedef struct packed {
		logic [7:0]       body_byte;
		logic             byte_valid;
		logic             body_done;
		logic [ERR_W-1:0] error_code;
	} result_t;

endpackage

FILE: design/hbd_if.sv
// ----------------------------------------------------------------------------
// hbd_raw_if / hbd_body_if
// Valid/ready channels for raw buffer bytes in and body bytes out.
// ----------------------------------------------------------------------------
interface hbd_raw_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;

	modport source (output valid, cmd, data_byte, input ready);
	modport sink (input valid, cmd, data_byte, output ready);
	modport monitor (input valid, ready, cmd, data_byte);
endinterface

interface hbd_body_if;
	logic                     valid;
	logic                     ready;
	logic [7:0]               body_byte;
	logic                     byte_valid;
	logic                     body_done;
	logic [hbd_pkg::ERR_W-1:0] error_code;

	modport source (output valid, body_byte, byte_valid, body_done, error_code, input ready);
	modport sink (input valid, body_byte, byte_valid, body_done, error_code, output ready);
	modport monitor (input valid, ready, body_byte, byte_valid, body_done, error_code);
endinterface

FILE: design/hbd_front.sv
// ----------------------------------------------------------------------------
// hbd_front
// Accepts raw transactions, classifies each byte (hex digit, CR, LF) and
// queues the classified item for the back end.
// ----------------------------------------------------------------------------
module hbd_front (
	input  logic           clk,
	input  logic           arst_n,
	hbd_raw_if.sink        raw,
	output logic           item_valid,
	output hbd_pkg::item_t item,
	input  logic           item_pop
);

	localparam int DEPTH = hbd_pkg::HBD_Q_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hbd_pkg::item_t           q_mem_q [DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q;
	logic [PTR_W-1:0]         rd_ptr_q;
	logic [CNT_W-1:0]         count_q;
	hbd_pkg::item_t           cls;
	logic                     push;
	logic                     pop;

	// byte classification
	always_comb begin
		cls           = '0;
		cls.cmd       = raw.cmd;
		cls.data_byte = raw.data_byte;
		cls.is_cr     = (raw.data_byte == 8'h0d);
		cls.is_lf     = (raw.data_byte == 8'h0a);
		if (raw.data_byte >= 8'h30 && raw.data_byte <= 8'h39) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = raw.data_byte[3:0];
		end else if (raw.data_byte >= 8'h61 && raw.data_byte <= 8'h66) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = 4'(raw.data_byte[3:0] + 4'd9);
		end else if (raw.data_byte >= 8'h41 && raw.data_byte <= 8'h46) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = 4'(raw.data_byte[3:0] + 4'd9);
		end
	end

	assign raw.ready  = (count_q != CNT_W'(DEPTH));
	assign push       = raw.valid && raw.ready;
	assign item_valid = (count_q != '0);
	assign pop        = item_pop && item_valid;
	assign item       = q_mem_q[rd_ptr_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

endmodule

FILE: design/hbd_back.sv
// ----------------------------------------------------------------------------
// hbd_back
// Parse engine: framing state machine, size accumulation and byte count,
// with an output register toward the body channel.
// ----------------------------------------------------------------------------
module hbd_back #(
	parameter int LEN_WIDTH = hbd_pkg::HBD_LEN_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hbd_pkg::cfg_t  cfg,
	input  logic           item_valid,
	input  hbd_pkg::item_t item,
	output logic           item_pop,
	hbd_body_if.source     body
);

	// parse phases
	localparam logic [2:0] PH_START   = 3'd0;
	localparam logic [2:0] PH_SIZE_LF = 3'd1;
	localparam logic [2:0] PH_DATA    = 3'd2;
	localparam logic [2:0] PH_DATA_CR = 3'd3;
	localparam logic [2:0] PH_DATA_LF = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;
	localparam logic [2:0] PH_ERROR   = 3'd6;
	localparam logic [2:0] PH_FIXED   = 3'd7;

	localparam logic [63:0] LEN_MAX64 = {64{1'b1}} >> (64 - LEN_WIDTH);

	logic [2:0]           phase_q, phase_d;
	logic [LEN_WIDTH-1:0] left_q, left_d;
	logic                 digit_q, digit_d;
	logic                 lsz_q, lsz_d;

	logic                 out_valid_q;
	hbd_pkg::result_t     out_q;
	hbd_pkg::result_t     res;
	logic                 res_v;

	logic [63:0]          blen64;
	logic [LEN_WIDTH-1:0] fix_len;
	logic [2:0]           ph;
	logic [LEN_WIDTH-1:0] cnt;
	logic                 complete;

	// fixed body length (zero when absent), saturated to the counter width
	assign blen64  = {{(64 - hbd_pkg::BODY_LEN_W){1'b0}}, cfg.body_length};
	assign fix_len = !cfg.length_present ? '0 :
		(blen64 > LEN_MAX64) ? '1 : blen64[LEN_WIDTH-1:0];

	assign complete = (phase_q == PH_DONE) ||
		(!cfg.chunked_mode && phase_q != PH_FIXED && phase_q != PH_ERROR &&
		 fix_len == '0);

	assign item_pop = item_valid && (!out_valid_q || body.ready);

	// next state and result of one item
	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		digit_d = digit_q;
		lsz_d   = lsz_q;
		res_v   = 1'b0;
		res     = '0;
		ph      = phase_q;
		cnt     = left_q;
		if (item.cmd == hbd_pkg::CMD_END) begin
			// end of buffer: report completion and restart
			res_v          = 1'b1;
			res.body_done  = complete;
			res.error_code = complete ? hbd_pkg::ERR_NONE :
				(phase_q == PH_ERROR) ? hbd_pkg::ERR_FRAMING : hbd_pkg::ERR_EARLY_END;
			phase_d = PH_START;
			left_d  = '0;
			digit_d = 1'b0;
			lsz_d   = 1'b0;
		end else if (phase_q == PH_DONE || phase_q == PH_ERROR) begin
			// late bytes dropped
		end else if (cfg.chunked_mode) begin
			// a phase of fixed mode restarts chunk parsing
			if (phase_q == PH_FIXED) begin
				ph      = PH_START;
				phase_d = PH_START;
				left_d  = '0;
				digit_d = 1'b0;
				lsz_d   = 1'b0;
			end
			unique case (ph)
				PH_START: begin
					if (item.is_cr) begin
						if (!digit_d) begin
							phase_d = PH_ERROR;
							res_v   = 1'b1;
						end else begin
							lsz_d   = (left_d == '0);
							phase_d = PH_SIZE_LF;
						end
					end else if (!item.is_hex || left_d[LEN_WIDTH-1 -: 4] != 4'd0) begin
						phase_d = PH_ERROR;
						res_v   = 1'b1;
					end else begin
						left_d  = {left_d[LEN_WIDTH-5:0], item.hex_val};
						digit_d = 1'b1;
					end
				end
				PH_SIZE_LF: begin
					if (!item.is_lf) begin
						phase_d = PH_ERROR;
						res_v   = 1'b1;
					end else if (lsz_q) begin
						phase_d       = PH_DONE;
						res_v         = 1'b1;
						res.body_done = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					left_d = LEN_WIDTH'(left_q - 1'b1);
					if (left_q == LEN_WIDTH'(1)) begin
						phase_d = PH_DATA_CR;
					end
					res_v          = 1'b1;
					res.body_byte  = item.data_byte;
					res.byte_valid = 1'b1;
				end
				PH_DATA_CR: begin
					if (!item.is_cr) begin
						phase_d = PH_ERROR;
						res_v   = 1'b1;
					end else begin
						phase_d = PH_DATA_LF;
					end
				end
				PH_DATA_LF: begin
					if (!item.is_lf) begin
						phase_d = PH_ERROR;
						res_v   = 1'b1;
					end else begin
						phase_d = PH_START;
						left_d  = '0;
						digit_d = 1'b0;
						lsz_d   = 1'b0;
					end
				end
				default: begin
				end
			endcase
			if (res_v && phase_d == PH_ERROR) begin
				res.error_code = hbd_pkg::ERR_FRAMING;
			end
		end else begin
			// fixed length body: load the count on the first byte
			if (phase_q != PH_FIXED) begin
				cnt     = fix_len;
				digit_d = 1'b0;
				lsz_d   = 1'b0;
			end
			if (cnt == '0) begin
				phase_d = PH_DONE;
				left_d  = '0;
			end else begin
				left_d         = LEN_WIDTH'(cnt - 1'b1);
				phase_d        = (cnt == LEN_WIDTH'(1)) ? PH_DONE : PH_FIXED;
				res_v          = 1'b1;
				res.body_byte  = item.data_byte;
				res.byte_valid = 1'b1;
				res.body_done  = (cnt == LEN_WIDTH'(1));
			end
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			left_q  <= '0;
			digit_q <= 1'b0;
			lsz_q   <= 1'b0;
		end else if (item_pop) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			digit_q <= digit_d;
			lsz_q   <= lsz_d;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_pop && res_v) begin
			out_valid_q <= 1'b1;
		end else if (body.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (item_pop && res_v) begin
			out_q <= res;
		end
	end

	assign body.valid      = out_valid_q;
	assign body.body_byte  = out_q.body_byte;
	assign body.byte_valid = out_q.byte_valid;
	assign body.body_done  = out_q.body_done;
	assign body.error_code = out_q.error_code;

endmodule

FILE: design/http_body_dechunker.sv
// ----------------------------------------------------------------------------
// http_body_dechunker
// Extracts an HTTP message body, fixed length or chunked, from a byte stream.
// ----------------------------------------------------------------------------
// The block takes one raw transaction per clock while the queue has room: a
// buffer byte or an end-of-buffer mark. The front end classifies each byte
// and puts it in a two-entry queue; the back end pops one item per cycle,
// updates the parse state (hex shift-in of the chunk size or one count
// decrement) and loads at most one result into an output register, and the
// sustained rate is one item per cycle as long as the body channel takes
// results. Items that give no result (size digits, CR/LF framing, dropped
// bytes) leave the block without a transaction. Configuration is written
// through cfg_we/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
module http_body_dechunker #(
	parameter int LEN_WIDTH = hbd_pkg::HBD_LEN_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hbd_pkg::CFG_DATA_W-1:0]  cfg_data,
	hbd_raw_if.sink                         raw,
	hbd_body_if.source                      body
);

	hbd_pkg::cfg_t  cfg_q;
	logic           item_valid;
	hbd_pkg::item_t item;
	logic           item_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hbd_pkg::CFG_CHUNKED_MODE:   cfg_q.chunked_mode   <= cfg_data[0];
				hbd_pkg::CFG_LENGTH_PRESENT: cfg_q.length_present <= cfg_data[0];
				hbd_pkg::CFG_BODY_LENGTH:
					cfg_q.body_length <= cfg_data[hbd_pkg::BODY_LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	hbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.raw        (raw),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	hbd_back #(
		.LEN_WIDTH (LEN_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.body       (body)
	);

endmodule

FILE: design/hbd_checker.sv
// ----------------------------------------------------------------------------
// hbd_checker
// Port-level checks on the body channel of the dechunker.
// ----------------------------------------------------------------------------
module hbd_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid,
	input  logic                      ready,
	input  logic [7:0]                body_byte,
	input  logic                      byte_valid,
	input  logic                      body_done,
	input  logic [hbd_pkg::ERR_W-1:0] error_code
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(body_byte) &&
		$stable(byte_valid) && $stable(body_done) && $stable(error_code))
		else $error("result changed while stalled");

	// data bytes never carry an error
	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid && byte_valid |-> error_code == hbd_pkg::ERR_NONE)
		else $error("data byte with error code");

	// completion and error exclude each other
	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid && error_code != hbd_pkg::ERR_NONE |-> !body_done)
		else $error("done flagged with error");

	// status-only results carry a zero byte
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !byte_valid |-> body_byte == 8'd0)
		else $error("status result with nonzero byte");

endmodule

bind http_body_dechunker hbd_checker u_hbd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (body.valid),
	.ready      (body.ready),
	.body_byte  (body.body_byte),
	.byte_valid (body.byte_valid),
	.body_done  (body.body_done),
	.error_code (body.error_code)
);

FILE: tb/hbd_body_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_body_checker
// Watches the raw and body channels and the register port of the HTTP body
// dechunker. It decodes every accepted raw transaction with its own copy of
// the parse state and queues the body transaction that it should cause. Each
// body transaction from the block is then compared with the oldest entry.
// ----------------------------------------------------------------------------
module hbd_body_checker
	import hbd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	hbd_raw_if.monitor            raw,
	hbd_body_if.monitor           body,
	output int                    mismatches,
	output int                    outstanding
);

	localparam int LW = HBD_LEN_WIDTH;
	localparam logic [LW-1:0] LEN_MAX = '1;
	localparam logic [7:0] CR = 8'h0d;
	localparam logic [7:0] LF = 8'h0a;

	typedef enum logic [2:0] {
		PH_START, PH_SIZE_LF, PH_DATA, PH_DATA_CR,
		PH_DATA_LF, PH_DONE, PH_ERROR, PH_FIXED
	} parse_phase_e;

	// shadow of the register file and of the parse state
	cfg_t         regs;
	parse_phase_e phase;
	logic [LW-1:0] left;
	logic          seen_digit;
	logic          zero_size;

	// body transactions still owed by the block, oldest first
	result_t due_body[$];

	function automatic int hex_digit(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	// declared length, saturated to the counter width
	function automatic logic [LW-1:0] fixed_len();
		if (!regs.length_present) return '0;
		if ((64'(regs.body_length) >> LW) != 0) return LEN_MAX;
		return LW'(regs.body_length);
	endfunction

	task automatic clear_parse();
		phase      = PH_START;
		left       = '0;
		seen_digit = 1'b0;
		zero_size  = 1'b0;
	endtask

	// one raw transaction in, at most one body transaction out
	task automatic dechunk_step(input logic cmd, input logic [7:0] c,
			output bit hit, output result_t r);
		int  d;
		bit  complete;
		hit = 1'b0;
		r   = '0;

		// end of buffer: report completion and start over
		if (cmd == CMD_END) begin
			complete = (phase == PH_DONE) || (!regs.chunked_mode &&
				phase != PH_FIXED && phase != PH_ERROR && fixed_len() == 0);
			r.body_done  = complete;
			r.error_code = complete ? ERR_NONE :
				(phase == PH_ERROR ? ERR_FRAMING : ERR_EARLY_END);
			clear_parse();
			hit = 1'b1;
			return;
		end
		if (phase == PH_DONE || phase == PH_ERROR) return;

		// fixed length body
		if (!regs.chunked_mode) begin
			if (phase != PH_FIXED) begin
				clear_parse();
				left = fixed_len();
				if (left == 0) begin
					phase = PH_DONE;
					return;
				end
				phase = PH_FIXED;
			end
			left         = left - 1'b1;
			hit          = 1'b1;
			r.body_byte  = c;
			r.byte_valid = 1'b1;
			if (left == 0) begin
				phase       = PH_DONE;
				r.body_done = 1'b1;
			end
			return;
		end

		// chunked body
		if (phase == PH_FIXED) clear_parse();
		case (phase)
			PH_START: begin
				if (c == CR) begin
					if (!seen_digit) begin
						hit = 1'b1;
					end else begin
						zero_size = (left == 0);
						phase     = PH_SIZE_LF;
					end
				end else begin
					d = hex_digit(c);
					if (d < 0 || left[LW-1:LW-4] != 0) begin
						hit = 1'b1;
					end else begin
						left       = {left[LW-5:0], 4'(d)};
						seen_digit = 1'b1;
					end
				end
			end
			PH_SIZE_LF: begin
				if (c != LF) begin
					hit = 1'b1;
				end else if (zero_size) begin
					phase       = PH_DONE;
					r.body_done = 1'b1;
					hit         = 1'b1;
					return;
				end else begin
					phase = PH_DATA;
				end
			end
			PH_DATA: begin
				left = left - 1'b1;
				if (left == 0) phase = PH_DATA_CR;
				hit          = 1'b1;
				r.body_byte  = c;
				r.byte_valid = 1'b1;
				return;
			end
			PH_DATA_CR: begin
				if (c != CR) hit = 1'b1;
				else phase = PH_DATA_LF;
			end
			PH_DATA_LF: begin
				if (c != LF) hit = 1'b1;
				else clear_parse();
			end
			default: ;
		endcase
		// any result that gets here is a framing error
		if (hit) begin
			r.error_code = ERR_FRAMING;
			phase        = PH_ERROR;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		bit      hit;
		if (!arst_n) begin
			regs = '0;
			clear_parse();
			due_body.delete();
			outstanding = 0;
			mismatches  = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHUNKED_MODE:   regs.chunked_mode   = cfg_data[0];
					CFG_LENGTH_PRESENT: regs.length_present = cfg_data[0];
					CFG_BODY_LENGTH:    regs.body_length    = cfg_data[BODY_LEN_W-1:0];
					default: ;
				endcase
			end

			// raw transaction accepted: predict
			if (raw.valid && raw.ready) begin
				dechunk_step(raw.cmd, raw.data_byte, hit, want);
				if (hit) due_body.push_back(want);
			end

			// body transaction accepted: compare with the oldest prediction
			if (body.valid && body.ready) begin
				got.body_byte  = body.body_byte;
				got.byte_valid = body.byte_valid;
				got.body_done  = body.body_done;
				got.error_code = body.error_code;
				if (due_body.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected body transaction: byte=%02h valid=%0b done=%0b err=%0d",
							$realtime, got.body_byte, got.byte_valid, got.body_done,
							got.error_code);
				end else begin
					want = due_body.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: body mismatch: got byte=%02h valid=%0b done=%0b err=%0d, want byte=%02h valid=%0b done=%0b err=%0d",
								$realtime, got.body_byte, got.byte_valid, got.body_done,
								got.error_code, want.body_byte, want.byte_valid,
								want.body_done, want.error_code);
					end
				end
			end
			outstanding = due_body.size();
		end
	end

endmodule

FILE: tb/tb_http_body_dechunker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_body_dechunker
// Stimulus and verdict for the HTTP body dechunker. A directed part walks the
// framing errors, size limits and fixed length corner cases; a random part
// sends well-formed chunked and fixed length buffers with random content,
// plus corrupted buffers and noise, under random pauses and back-pressure.
// Checking is done by hbd_body_checker beside the block.
// ----------------------------------------------------------------------------
module tb_http_body_dechunker;
	import hbd_pkg::*;

	localparam int LIMIT = 1000000;
	localparam int ITEM_TARGET = 1250;
	localparam int SETTLE = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [7:0] CR = 8'h0d;
	localparam logic [7:0] LF = 8'h0a;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	hbd_raw_if  raw();
	hbd_body_if body();

	int   mismatches;
	int   outstanding;
	int   cycles = 0;
	int   items_sent = 0;
	bit   calm = 1'b0;
	logic [7:0] frame[$];

	http_body_dechunker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.raw       (raw.sink),
		.body      (body.source)
	);

	hbd_body_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.raw         (raw.monitor),
		.body        (body.monitor),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// mostly short pauses, now and then a long one
	function automatic int pause_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// body side back-pressure
	initial begin
		int hold;
		hold = 0;
		body.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				body.ready = 1'b1;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 99) < 65) begin
				body.ready = 1'b1;
				hold = $urandom_range(0, 8);
			end else begin
				body.ready = 1'b0;
				hold = pause_len();
			end
		end
	end

	// one raw transaction; called and returns just after a falling edge
	task automatic push_item(input logic cmd, input logic [7:0] b);
		int gap;
		gap = calm ? 0 : pause_len();
		if (gap > 0) begin
			raw.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		raw.valid     = 1'b1;
		raw.cmd       = cmd;
		raw.data_byte = b;
		do @(posedge clk); while (!raw.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic push_text(input string s);
		foreach (s[i]) push_item(CMD_BYTE, s[i]);
	endtask

	// line end of a size line or of chunk data
	task automatic push_crlf();
		push_item(CMD_BYTE, CR);
		push_item(CMD_BYTE, LF);
	endtask

	task automatic end_buffer();
		push_item(CMD_END, 8'($urandom_range(0, 255)));
	endtask

	// stop sending and wait until every owed body transaction has arrived
	task automatic drain();
		raw.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		drain();
		repeat (SETTLE) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
		if (nib < 10) return 8'("0") + 8'(nib);
		return (upper ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
	endfunction

	// chunk size line, mixed case, optional leading zeros
	function automatic void put_size(logic [31:0] n);
		bit started;
		started = 1'b0;
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) frame.push_back("0");
		for (int k = 7; k >= 0; k--) begin
			if (n[4*k +: 4] != 0 || started || k == 0) begin
				started = 1'b1;
				frame.push_back(hex_char(n[4*k +: 4], $urandom_range(0, 1)));
			end
		end
		frame.push_back(CR);
		frame.push_back(LF);
	endfunction

	// bytes that tend to matter to the size line parser
	function automatic logic [7:0] noisy_byte();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 255));
			1: return 8'("0") + 8'($urandom_range(0, 9));
			2: return hex_char(4'($urandom_range(10, 15)), $urandom_range(0, 1));
			default: return $urandom_range(0, 1) ? CR : LF;
		endcase
	endfunction

	// well-formed chunked body with random content
	function automatic void build_chunked();
		int unsigned sz;
		frame.delete();
		repeat ($urandom_range(0, 3)) begin
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 20);
			put_size(sz);
			repeat (sz) frame.push_back(8'($urandom_range(0, 255)));
			frame.push_back(CR);
			frame.push_back(LF);
		end
		put_size(0);
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
			frame.push_back(8'($urandom_range(0, 255)));
	endfunction

	// flip, cut short or insert one byte
	function automatic void corrupt_frame();
		int pos;
		if (frame.size() == 0) return;
		pos = $urandom_range(0, frame.size() - 1);
		case ($urandom_range(0, 2))
			0: frame[pos] = noisy_byte();
			1: while (frame.size() > pos) void'(frame.pop_back());
			default: frame.insert(pos, noisy_byte());
		endcase
	endfunction

	task automatic send_frame(input bit with_end);
		foreach (frame[i]) push_item(CMD_BYTE, frame[i]);
		if (with_end) end_buffer();
	endtask

	initial begin
		bit          chunked;
		logic [31:0] blen;
		int          p;
		int          nbuf;
		int          fixed_span;

		raw.valid     = 1'b0;
		raw.cmd       = CMD_BYTE;
		raw.data_byte = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset registers: fixed mode, no length, so the first byte is dropped
		push_text("A");
		end_buffer();
		write_reg(CFG_SPARE, '1);

		// chunked: data extremes, zero-size end, bytes after completion
		write_reg(CFG_CHUNKED_MODE, 1);
		push_text("2");
		push_crlf();
		push_item(CMD_BYTE, 8'h00);
		push_item(CMD_BYTE, 8'hff);
		push_crlf();
		push_text("0");
		push_crlf();
		push_text("x");
		end_buffer();
		// CR of a size line not followed by LF
		push_text("fA");
		push_item(CMD_BYTE, CR);
		push_text("Z");
		end_buffer();
		// empty size line
		push_item(CMD_BYTE, CR);
		end_buffer();
		// non-hex size byte
		push_text("g");
		end_buffer();
		// largest size, then a digit that overflows it
		push_text("FFFFFFFF0");
		end_buffer();
		// data not followed by CR
		push_text("1");
		push_crlf();
		push_text("xy");
		end_buffer();
		// buffer ends inside the data
		push_text("5");
		push_crlf();
		push_text("a");
		end_buffer();

		// fixed length: short body, zero length, largest length
		write_reg(CFG_CHUNKED_MODE, 0);
		write_reg(CFG_LENGTH_PRESENT, 1);
		write_reg(CFG_BODY_LENGTH, 2);
		push_text("pqr");
		end_buffer();
		write_reg(CFG_BODY_LENGTH, 0);
		push_text("s");
		end_buffer();
		write_reg(CFG_BODY_LENGTH, '1);
		push_text("t");
		end_buffer();

		// random phases, each under one register setting
		while (items_sent < ITEM_TARGET) begin
			chunked = ($urandom_range(0, 99) < 65);
			p = $urandom_range(0, 99);
			if (p < 10) blen = 0;
			else if (p < 15) blen = '1;
			else if (p < 20) blen = $urandom;
			else blen = $urandom_range(1, 40);
			write_reg(CFG_CHUNKED_MODE, CFG_DATA_W'(chunked));
			write_reg(CFG_LENGTH_PRESENT, CFG_DATA_W'($urandom_range(0, 3) != 0));
			write_reg(CFG_BODY_LENGTH, blen);
			calm = ($urandom_range(0, 4) == 0);
			nbuf = $urandom_range(3, 8);
			fixed_span = (blen > 40) ? 40 : int'(blen);
			for (int b = 0; b < nbuf; b++) begin
				p = $urandom_range(0, 99);
				frame.delete();
				if (p < 5) begin
					repeat ($urandom_range(1, 10)) frame.push_back(noisy_byte());
				end else if (chunked) begin
					build_chunked();
					if (p < 20) corrupt_frame();
				end else begin
					repeat ($urandom_range(0, fixed_span + 4))
						frame.push_back(8'($urandom_range(0, 255)));
				end
				// the last buffer of a phase may stay open across the mode change
				send_frame(!(b == nbuf - 1 && $urandom_range(0, 3) == 0));
			end
			calm = 1'b0;
		end

		// wind down and give the verdict
		drain();
		repeat (SETTLE + 2) @(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sim.f
design/hbd_pkg.sv
design/hbd_if.sv
design/hbd_front.sv
design/hbd_back.sv
design/http_body_dechunker.sv
design/hbd_checker.sv
tb/hbd_body_checker.sv
tb/tb_http_body_dechunker.sv
